@@ sv/pll_coefficient_search_macros.svh @@
// Assertion macros shared by the checker of the PLL coefficient search block.
// Depends on nothing; included by the checker file.
`ifndef PLL_COEFFICIENT_SEARCH_MACROS_SVH
`define PLL_COEFFICIENT_SEARCH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/pcs_pkg.sv @@
// Shared types, constants and helpers of the PLL coefficient search block.
// Depends on nothing; imported by every module of the block.
package pcs_pkg;

  localparam int RATE_W   = 32;
  localparam int NF_W     = 13;
  localparam int NR_W     = 7;
  localparam int OD_W     = 5;
  localparam int WORD_W   = 31;
  localparam int DVD_W    = 42;
  localparam int DVS_W    = 32;
  localparam int VCO_W    = 36;
  localparam int ODI_W    = 4;
  localparam int CNT_W    = 6;
  localparam int DIV_STEPS = DVD_W;
  localparam int OD_COUNT = 9;

  localparam logic [NR_W-1:0]   NR_LIMIT = 7'd64;
  localparam logic [DVD_W-1:0]  VCO_MAX  = 42'd3600000000;
  localparam logic [DVD_W-1:0]  VCO_MIN  = 42'd720000000;
  localparam logic [DVD_W-1:0]  NF_MAX   = 42'd4096;
  localparam logic [RATE_W-1:0] RATE_MAX = 32'd3600000000;
  localparam logic [ODI_W-1:0]  ODI_LAST = 4'(OD_COUNT - 1);

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_MAX_REF = 2'd0,
    REG_PARENT  = 2'd1
  } pcs_reg_t;

  // Search sequencer states.
  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_NF_GO, S_NF_WAIT, S_VCO_GO, S_VCO_WAIT,
    S_FR_GO, S_FR_WAIT, S_NEXT_OD, S_NEXT_NR, S_DECIDE, S_FINISH
  } pcs_state_t;

  // Request to the shared divider.
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } pcs_div_req_t;

  // One result beat.
  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic [NF_W-1:0]   nf;
    logic [NR_W-1:0]   nr;
    logic [OD_W-1:0]   od;
    logic              bypass;
    logic              err;
    logic [WORD_W-1:0] word;
  } pcs_result_t;

  // Output divider list, largest first.
  function automatic logic [OD_W-1:0] od_of(input logic [ODI_W-1:0] idx);
    logic [OD_W-1:0] od;
    case (idx)
      4'd0:    od = 5'd16;
      4'd1:    od = 5'd14;
      4'd2:    od = 5'd12;
      4'd3:    od = 5'd10;
      4'd4:    od = 5'd8;
      4'd5:    od = 5'd6;
      4'd6:    od = 5'd4;
      4'd7:    od = 5'd2;
      default: od = 5'd1;
    endcase
    return od;
  endfunction

  // Packed PLL config word; callers pass nonzero coefficients.
  function automatic logic [WORD_W-1:0] pack_word(input logic [NF_W-1:0] nf,
                                                  input logic [NR_W-1:0] nr,
                                                  input logic [OD_W-1:0] od);
    logic [NF_W-1:0] nfm;
    logic [NR_W-1:0] nrm;
    logic [OD_W-1:0] odm;
    logic [WORD_W-1:0] w;
    nfm = nf - 1'b1;
    nrm = nr - 1'b1;
    odm = od - 1'b1;
    w = '0;
    w[30:27] = nrm[3:0];
    w[26:14] = nfm;
    w[13:10] = odm[3:0];
    w[9]     = 1'b1;
    w[7:0]   = 8'd1;
    return w;
  endfunction

endpackage

@@ sv/pcs_divider.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on pcs_pkg for widths and the request struct.
module pcs_divider import pcs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  pcs_div_req_t     req,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] div_r, div_nxt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  // One compare and subtract per cycle; the dividend shifts out as quotient shifts in.
  always_comb begin
    trial    = {rem_r, quo_r[DVD_W-1]};
    ge       = trial >= {1'b0, div_r};
    diff     = trial - {1'b0, div_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      div_nxt  = req.divisor;
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

@@ sv/pll_coefficient_search.sv @@
// PLL coefficient search block, top level.
// Depends on pcs_pkg and pcs_divider.
//
// Usage: write max_ref_divider (index 0) and the reference clock rate
// (index 1) through the cfg port while the block is idle. Present a target
// rate on the input channel; one result beat follows on the output channel
// for each input beat.
// The search walks NR from 1 to min(max_ref_divider, 64) and, for each NR,
// the output dividers 16 down to 1. Each candidate runs up to three
// 42-step divisions on one shared divider, and one beat tries at most
// 64 x 9 candidates; a zero reference rate skips the search, and with no NR
// to try the search goes straight to the final decision.
// in_stall stays high from acceptance until the result is placed in the
// output register; one item is in work at a time.
// A stalled result holds in the output register; the next input beat may be
// accepted while it waits, and its result waits for the register to empty.
// Reset restores max_ref_divider to 1 and the reference clock rate to
// 27000000 and empties the block.
module pll_coefficient_search import pcs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [31:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [RATE_W-1:0]   in_target_rate,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [RATE_W-1:0]   out_achieved_rate,
  output logic [NF_W-1:0]     out_feedback_mult,
  output logic [NR_W-1:0]     out_ref_div,
  output logic [OD_W-1:0]     out_out_div,
  output logic                out_bypass_sel,
  output logic                out_error_flag,
  output logic [WORD_W-1:0]   out_pll_word
);

  pcs_state_t        state_r, state_nxt;
  logic [NR_W-1:0]   max_ref_r, max_ref_nxt;
  logic [RATE_W-1:0] parent_r, parent_nxt;
  logic [RATE_W-1:0] rate_r, rate_nxt;
  logic [NR_W-1:0]   nr_r, nr_nxt;
  logic [ODI_W-1:0]  odi_r, odi_nxt;
  logic [DVD_W-1:0]  prod_r, prod_nxt;
  logic [NF_W-1:0]   nf_r, nf_nxt;
  logic              nf_big_r, nf_big_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [VCO_W-1:0]  vco_r, vco_nxt;
  logic [RATE_W-1:0] best_r, best_nxt;
  logic [NF_W-1:0]   best_nf_r, best_nf_nxt;
  logic [NR_W-1:0]   best_nr_r, best_nr_nxt;
  logic [OD_W-1:0]   best_od_r, best_od_nxt;
  pcs_result_t       res_r, res_nxt;
  pcs_result_t       out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              in_acc;
  logic              out_free;
  logic [NR_W-1:0]   lim;
  logic [OD_W-1:0]   od;
  logic [11:0]       nr_od;
  logic [43:0]       mul;
  pcs_div_req_t      div_req;
  logic              div_done;
  logic [DVD_W-1:0]  div_q;
  logic [DVS_W-1:0]  div_r;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign lim      = (max_ref_r > NR_LIMIT) ? NR_LIMIT : max_ref_r;
  assign od       = od_of(odi_r);
  assign nr_od    = 12'(nr_r) * 12'(od);
  assign mul      = 44'(rate_r) * 44'(nr_od);

  pcs_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (div_req),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Next state of the search sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (parent_r == '0)   state_nxt = S_FINISH;
          else if (lim == '0)   state_nxt = S_DECIDE;
          else                  state_nxt = S_MUL;
        end
      end
      S_MUL:     state_nxt = S_NF_GO;
      S_NF_GO:   state_nxt = S_NF_WAIT;
      S_NF_WAIT: begin
        if (div_done) state_nxt = (div_q == '0) ? S_NEXT_NR : S_VCO_GO;
      end
      S_VCO_GO:  state_nxt = S_VCO_WAIT;
      S_VCO_WAIT: begin
        if (div_done) begin
          if (div_q < VCO_MIN)                  state_nxt = S_NEXT_NR;
          else if (nf_big_r || div_q > VCO_MAX) state_nxt = S_NEXT_OD;
          else                                  state_nxt = S_FR_GO;
        end
      end
      S_FR_GO:   state_nxt = S_FR_WAIT;
      S_FR_WAIT: begin
        if (div_done) state_nxt = (rem_r == '0) ? S_FINISH : S_NEXT_OD;
      end
      S_NEXT_OD: state_nxt = (odi_r == ODI_LAST) ? S_NEXT_NR : S_MUL;
      S_NEXT_NR: state_nxt = (nr_r == lim) ? S_DECIDE : S_MUL;
      S_DECIDE:  state_nxt = S_FINISH;
      S_FINISH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Divider requests issued by the sequencer.
  always_comb begin
    div_req = '0;
    unique case (state_r)
      S_NF_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_r;
        div_req.divisor  = parent_r;
      end
      S_VCO_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_r - DVD_W'(rem_r);
        div_req.divisor  = DVS_W'(nr_r);
      end
      S_FR_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = (rem_r == '0) ? DVD_W'(vco_r) + DVD_W'(od >> 1)
                                         : DVD_W'(vco_r);
        div_req.divisor  = DVS_W'(od);
      end
      default: div_req = '0;
    endcase
  end

  // Search datapath, configuration and output register updates.
  always_comb begin
    max_ref_nxt = max_ref_r;
    parent_nxt  = parent_r;
    rate_nxt    = rate_r;
    nr_nxt      = nr_r;
    odi_nxt     = odi_r;
    prod_nxt    = prod_r;
    nf_nxt      = nf_r;
    nf_big_nxt  = nf_big_r;
    rem_nxt     = rem_r;
    vco_nxt     = vco_r;
    best_nxt    = best_r;
    best_nf_nxt = best_nf_r;
    best_nr_nxt = best_nr_r;
    best_od_nxt = best_od_r;
    res_nxt     = res_r;
    out_nxt     = out_r;

    if (cfg_we) begin
      case (cfg_addr)
        REG_MAX_REF: max_ref_nxt = cfg_wdata[NR_W-1:0];
        REG_PARENT:  parent_nxt  = cfg_wdata;
        default:     ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          rate_nxt    = (in_target_rate > RATE_MAX) ? RATE_MAX : in_target_rate;
          nr_nxt      = NR_W'(1);
          odi_nxt     = '0;
          best_nxt    = parent_r;
          best_nf_nxt = '0;
          best_nr_nxt = '0;
          best_od_nxt = '0;
          res_nxt     = '0;
          res_nxt.err = 1'b1;
        end
      end
      S_MUL: prod_nxt = mul[DVD_W-1:0];
      S_NF_WAIT: begin
        if (div_done) begin
          nf_nxt     = div_q[NF_W-1:0];
          nf_big_nxt = div_q > NF_MAX;
          rem_nxt    = div_r;
        end
      end
      S_VCO_WAIT: begin
        if (div_done) vco_nxt = div_q[VCO_W-1:0];
      end
      S_FR_WAIT: begin
        if (div_done) begin
          if (rem_r == '0) begin
            res_nxt.rate   = div_q[RATE_W-1:0];
            res_nxt.nf     = nf_r;
            res_nxt.nr     = nr_r;
            res_nxt.od     = od;
            res_nxt.bypass = 1'b0;
            res_nxt.err    = 1'b0;
            res_nxt.word   = pack_word(nf_r, nr_r, od);
          end else if (div_q[RATE_W-1:0] > best_r) begin
            best_nxt    = div_q[RATE_W-1:0];
            best_nf_nxt = nf_r;
            best_nr_nxt = nr_r;
            best_od_nxt = od;
          end
        end
      end
      S_NEXT_OD: odi_nxt = odi_r + 1'b1;
      S_NEXT_NR: begin
        nr_nxt  = nr_r + 1'b1;
        odi_nxt = '0;
      end
      S_DECIDE: begin
        res_nxt = '0;
        if (best_r == parent_r) begin
          res_nxt.rate   = parent_r;
          res_nxt.bypass = 1'b1;
        end else begin
          res_nxt.rate = best_r;
          res_nxt.nf   = best_nf_r;
          res_nxt.nr   = best_nr_r;
          res_nxt.od   = best_od_r;
          res_nxt.word = pack_word(best_nf_r, best_nr_r, best_od_r);
        end
      end
      S_FINISH: begin
        if (out_free) out_nxt = res_r;
      end
      default: ;
    endcase

    // Output register: loads on finish, empties when the beat is taken.
    if (state_r == S_FINISH && out_free) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall)  out_valid_nxt = 1'b0;
    else                                 out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_ref_r   <= NR_W'(1);
      parent_r    <= 32'd27000000;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      max_ref_r   <= max_ref_nxt;
      parent_r    <= parent_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rate_r    <= rate_nxt;
    nr_r      <= nr_nxt;
    odi_r     <= odi_nxt;
    prod_r    <= prod_nxt;
    nf_r      <= nf_nxt;
    nf_big_r  <= nf_big_nxt;
    rem_r     <= rem_nxt;
    vco_r     <= vco_nxt;
    best_r    <= best_nxt;
    best_nf_r <= best_nf_nxt;
    best_nr_r <= best_nr_nxt;
    best_od_r <= best_od_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_achieved_rate = out_r.rate;
  assign out_feedback_mult = out_r.nf;
  assign out_ref_div       = out_r.nr;
  assign out_out_div       = out_r.od;
  assign out_bypass_sel    = out_r.bypass;
  assign out_error_flag    = out_r.err;
  assign out_pll_word      = out_r.word;

endmodule

@@ sv/pcs_checker.sv @@
// Port-level checker of the PLL coefficient search block, bound to the top.
// Depends on pcs_pkg and pll_coefficient_search_macros.svh.
`include "pll_coefficient_search_macros.svh"

module pcs_checker import pcs_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [RATE_W-1:0] out_achieved_rate,
  input logic [NF_W-1:0]   out_feedback_mult,
  input logic [NR_W-1:0]   out_ref_div,
  input logic [OD_W-1:0]   out_out_div,
  input logic              out_bypass_sel,
  input logic              out_error_flag,
  input logic [WORD_W-1:0] out_pll_word
);

  // A stalled result beat stays offered.
  `PCS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // The block takes no second beat right after accepting one.
  `PCS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

  // An error beat carries nothing but the flag.
  `PCS_ASSERT_NOW(a_error_clean, clk, rst_n, out_valid && out_error_flag,
    out_achieved_rate == '0 && out_feedback_mult == '0 && out_ref_div == '0 &&
    out_out_div == '0 && !out_bypass_sel && out_pll_word == '0)

  // A bypass beat has no coefficients and no config word.
  `PCS_ASSERT_NOW(a_bypass_clean, clk, rst_n, out_valid && out_bypass_sel,
    out_feedback_mult == '0 && out_ref_div == '0 && out_out_div == '0 &&
    out_pll_word == '0 && !out_error_flag)

endmodule

bind pll_coefficient_search pcs_checker u_pcs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_achieved_rate (out_achieved_rate),
  .out_feedback_mult (out_feedback_mult),
  .out_ref_div       (out_ref_div),
  .out_out_div       (out_out_div),
  .out_bypass_sel    (out_bypass_sel),
  .out_error_flag    (out_error_flag),
  .out_pll_word      (out_pll_word)
);

@@ bench/pll_coefficient_search_tb.sv @@
// Self-checking testbench of the PLL coefficient search block.
// Depends on pcs_pkg and the pll_coefficient_search RTL.
// Drives target rates with bursty traffic, predicts each result and compares it.
module pll_coefficient_search_tb;
  import pcs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned CYCLE_LIMIT = 6000000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_addr = '0;
  logic [31:0]         cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [RATE_W-1:0]   in_target_rate = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [RATE_W-1:0]   out_achieved_rate;
  logic [NF_W-1:0]     out_feedback_mult;
  logic [NR_W-1:0]     out_ref_div;
  logic [OD_W-1:0]     out_out_div;
  logic                out_bypass_sel;
  logic                out_error_flag;
  logic [WORD_W-1:0]   out_pll_word;

  // Local copy of the two configuration registers.
  logic [NR_W-1:0] cur_max_ref;
  logic [31:0]     cur_parent;

  pcs_result_t     pending_results[$];
  int              mismatches = 0;
  longint unsigned cycles = 0;
  int              burst_left = 0;
  int              stall_pct = 0;

  pll_coefficient_search dut (.*);

  always #5 clk = ~clk;

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("pll_coefficient_search_tb NOT OK");
      $finish;
    end
  end

  // The receiver stalls with a randomly changing duty.
  always @(posedge clk) begin
    if (cycles % 300 == 0) begin
      case ($urandom_range(0, 2))
        0: stall_pct <= 0;
        1: stall_pct <= 30;
        default: stall_pct <= 75;
      endcase
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Builds one result beat from chosen coefficients.
  function automatic pcs_result_t make_result(longint unsigned rate, longint unsigned nf,
                                              longint unsigned nr, longint unsigned od,
                                              bit bypass, bit err);
    pcs_result_t r;
    longint unsigned w;
    w = 0;
    if (nr != 0 && nf != 0 && od != 0)
      w = (((nf - 1) & 'h1FFF) << 14) | (((nr - 1) & 'hF) << 27) |
          (((od - 1) & 'hF) << 10) | 1 | (1 << 9);
    r.rate   = rate[31:0];
    r.nf     = nf[NF_W-1:0];
    r.nr     = nr[NR_W-1:0];
    r.od     = od[OD_W-1:0];
    r.bypass = bypass;
    r.err    = err;
    r.word   = w[WORD_W-1:0];
    return r;
  endfunction

  // Coefficient search as the block should perform it.
  function automatic pcs_result_t predict_search(logic [31:0] target);
    longint unsigned rate, parent, lim, best, bnf, bnr, bod;
    longint unsigned od, prod, nf, rem, vco, freq;
    longint unsigned od_list [9];
    od_list = '{16, 14, 12, 10, 8, 6, 4, 2, 1};
    rate = target;
    parent = cur_parent;
    lim = cur_max_ref;
    best = parent;
    bnf = 0;
    bnr = 0;
    bod = 0;
    if (parent == 0) return make_result(0, 0, 0, 0, 1'b0, 1'b1);
    if (rate > 64'd3600000000) rate = 64'd3600000000;
    if (lim > 64) lim = 64;
    for (longint unsigned nr = 1; nr <= lim; nr++) begin
      for (int i = 0; i < 9; i++) begin
        od = od_list[i];
        prod = rate * nr * od;
        nf = prod / parent;
        rem = prod % parent;
        vco = parent * nf / nr;
        if (nf == 0 || vco < 64'd720000000) break;
        if (nf > 4096 || vco > 64'd3600000000) continue;
        // An exact division wins at once.
        if (rem == 0) return make_result((vco + od / 2) / od, nf, nr, od, 1'b0, 1'b0);
        freq = vco / od;
        if (freq > best) begin
          best = freq;
          bnf = nf;
          bnr = nr;
          bod = od;
        end
      end
    end
    if (best == parent) return make_result(parent, 0, 0, 0, 1'b1, 1'b0);
    return make_result(best, bnf, bnr, bod, 1'b0, 1'b0);
  endfunction

  // Compares each accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    pcs_result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_achieved_rate, out_feedback_mult, out_ref_div, out_out_div,
              out_bypass_sel, out_error_flag, out_pll_word};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // One register write; the write port is left idle before the task returns.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAX_REF) cur_max_ref = val[NR_W-1:0];
    else if (idx == REG_PARENT) cur_parent = val;
    @(posedge clk);
  endtask

  task automatic set_config(logic [31:0] max_ref, logic [31:0] parent);
    write_reg(REG_MAX_REF, max_ref);
    write_reg(REG_PARENT, parent);
  endtask

  // Sends one target rate beat; bursts end with a random gap.
  task automatic send_rate(logic [31:0] rate);
    in_target_rate <= rate;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    pending_results.push_back(predict_search(rate));
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = $urandom_range(0, 4);
    end else begin
      burst_left--;
    end
  endtask

  // Holds off the sender until every predicted result has arrived.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic test_reset_values();
    send_rate(32'd0);
    send_rate(32'd27000000);
    send_rate(32'd1000000000);
    send_rate(32'd3600000000);
    send_rate(32'hFFFF_FFFF);
    send_rate(32'd148500000);
    wait_idle();
  endtask

  task automatic test_zero_parent();
    set_config(32'd4, 32'd0);
    send_rate(32'd500000000);
    send_rate(32'hFFFF_FFFF);
    wait_idle();
  endtask

  task automatic test_bypass();
    set_config(32'd2, 32'hFFFF_FFFF);
    send_rate(32'd100000000);
    send_rate(32'd0);
    wait_idle();
    set_config(32'd0, 32'd27000000);
    send_rate(32'd800000000);
    wait_idle();
  endtask

  // Saturation of the reference divider limit and wide NR packing.
  task automatic test_ref_limit();
    set_config(32'h7F, 32'd25000000);
    send_rate(32'd1234567891);
    wait_idle();
    set_config(32'd64, 32'd48000000);
    send_rate(32'd997000001);
    wait_idle();
    set_config(32'd20, 32'd19200000);
    send_rate(32'd3599999999);
    send_rate(32'd733333333);
    wait_idle();
  endtask

  // Writes to unused register indexes must not disturb anything.
  task automatic test_unused_index();
    write_reg(2'd2, 32'hFFFF_FFFF);
    write_reg(2'd3, 32'h0000_0000);
    send_rate(32'd1188000000);
    send_rate(32'd750000000);
    wait_idle();
  endtask

  task automatic test_random();
    logic [31:0] parent, max_ref, rate;
    for (int phase = 0; phase < 14; phase++) begin
      // Mostly realistic reference clocks, sometimes anything.
      parent = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1000000, 150000000);
      max_ref = (phase == 5) ? 64 : $urandom_range(1, 6);
      max_ref[31:7] = 25'($urandom());
      if (phase == 5) max_ref = 32'd64;
      set_config(max_ref, parent);
      for (int k = 0; k < 7; k++) begin
        case ($urandom_range(0, 3))
          0: rate = $urandom();
          1: rate = $urandom_range(0, 200000000);
          2: rate = (parent / $urandom_range(1, 16)) * $urandom_range(1, 60);
          default: rate = $urandom_range(700000000, 3600000000);
        endcase
        send_rate(rate);
        if (phase == 5 && k == 1) break;
      end
      wait_idle();
    end
  endtask

  initial begin
    cur_max_ref = 7'd1;
    cur_parent = 32'd27000000;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_zero_parent();
    test_bypass();
    test_ref_limit();
    test_unused_index();
    test_random();
    wait_idle();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("pll_coefficient_search_tb OK");
    end else begin
      $display("pll_coefficient_search_tb NOT OK");
    end
    $finish;
  end
endmodule
